// ===== rtl/pss_pkg.sv =====
package pss_pkg;

    // Field widths of the transfer payloads and configuration registers.
    localparam int ADDR_W    = 48;
    localparam int BYTES_W   = 19;
    localparam int TAG_W     = 16;
    localparam int FUNC_W    = 2;
    localparam int MODE_W    = 2;
    localparam int IO_LAT_W  = 8;
    localparam int CYC_W     = 16;
    localparam int SKIP_W    = 20;
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 4;
    localparam int REG_IDX_W = 2;

    // Saturation limits of the internal counters.
    localparam logic [CYC_W-1:0]  IDLE_MAX = '1;
    localparam logic [SKIP_W-1:0] SKIP_MAX = '1;

    // Defaults for the top-level parameters.
    localparam int LINE_BYTES_DEF = 64;
    localparam int MAX_LINES_DEF  = 4096;
    localparam int ADDR_BITS_DEF  = 48;

    // Item kinds.
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REQ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESP = 2'd2;

    // Reported power mode codes.
    localparam logic [MODE_W-1:0] MODE_ACTIVE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOW    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd2;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_IO_LATENCY  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ENTER       = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOW_EXIT    = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_IDLE_EXIT   = 2'd3;

    // Internal power state, one-hot.
    typedef enum logic [2:0] {
        PM_ACTIVE = 3'b001,
        PM_LOW    = 3'b010,
        PM_IDLE   = 3'b100
    } pm_state_t;

    // One result item.
    typedef struct packed {
        logic              job_taken;
        logic              line_sent;
        logic [ADDR_W-1:0] line_addr;
        logic              line_is_read;
        logic              job_done;
        logic [TAG_W-1:0]  done_tag;
        logic [MODE_W-1:0] power_mode;
        logic              did_work;
    } res_t;

endpackage

// ===== rtl/pss_out_buf.sv =====
module pss_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  pss_pkg::res_t     push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output pss_pkg::res_t     pop_data
);

    logic          main_valid_reg;
    logic          skid_valid_reg;
    pss_pkg::res_t main_data_reg;
    pss_pkg::res_t skid_data_reg;
    logic          push;
    logic          pop;

    // Input side stays open until the skid entry is occupied.
    assign push_ready = !skid_valid_reg;
    assign push       = push_valid && push_ready;
    assign pop        = main_valid_reg && pop_ready;
    assign pop_valid  = main_valid_reg;
    assign pop_data   = main_data_reg;

    // Valid flags of the two entries.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    // Payload moves from the skid entry or straight from the input.
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_data_reg <= skid_data_reg;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_data_reg <= push_data;
            end else begin
                main_data_reg <= push_data;
            end
        end
    end

endmodule

// ===== rtl/ip_power_state_request_sequencer_unit.sv =====
// Power-managed request sequencer. Every item (tick, job request or memory
// response) yields a single result, which is registered in the output buffer
// that drives the m_ channel; with the result side ready, one item is
// accepted every cycle. A two-entry output buffer keeps s_ready high while
// one result waits, so input only stalls after two results are held back.
// All state updates for an item happen in the cycle it is accepted, so the
// block never stalls on its own. Registers are written and read over the
// APB port, which has no wait states; write them only while the block is idle.
module ip_power_state_request_sequencer_unit #(
    parameter int LINE_BYTES = pss_pkg::LINE_BYTES_DEF,
    parameter int MAX_LINES  = pss_pkg::MAX_LINES_DEF,
    parameter int ADDR_BITS  = pss_pkg::ADDR_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pss_pkg::PADDR_W-1:0]   paddr,
    input  logic [pss_pkg::PDATA_W-1:0]   pwdata,
    output logic [pss_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    // Input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pss_pkg::FUNC_W-1:0]    s_func,
    input  logic                          s_mem_accept,
    input  logic [pss_pkg::ADDR_W-1:0]    s_job_addr,
    input  logic [pss_pkg::BYTES_W-1:0]   s_job_bytes,
    input  logic                          s_job_is_read,
    input  logic [pss_pkg::TAG_W-1:0]     s_job_tag,
    // Result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_job_taken,
    output logic                          m_line_sent,
    output logic [pss_pkg::ADDR_W-1:0]    m_line_addr,
    output logic                          m_line_is_read,
    output logic                          m_job_done,
    output logic [pss_pkg::TAG_W-1:0]     m_done_tag,
    output logic [pss_pkg::MODE_W-1:0]    m_power_mode,
    output logic                          m_did_work
);

    localparam int LCNT_W = $clog2(MAX_LINES + 1);
    localparam int LRAW_W = pss_pkg::BYTES_W + 1;
    localparam int PROD_W = pss_pkg::IO_LAT_W + LCNT_W;
    localparam int NA_W   = (ADDR_BITS < pss_pkg::ADDR_W) ? ADDR_BITS : pss_pkg::ADDR_W;
    localparam logic [LRAW_W-1:0] MAX_LINES_RAW = LRAW_W'(MAX_LINES);
    localparam logic [LCNT_W-1:0] MAX_LINES_CNT = LCNT_W'(MAX_LINES);

    // Configuration registers
    logic [pss_pkg::IO_LAT_W-1:0] io_latency_reg;
    logic [pss_pkg::CYC_W-1:0]    enter_cycles_reg;
    logic [pss_pkg::CYC_W-1:0]    low_exit_reg;
    logic [pss_pkg::CYC_W-1:0]    idle_exit_reg;
    logic [pss_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          cfg_write;

    // Sequencer state
    pss_pkg::pm_state_t          pm_reg, pm_next;
    logic                        busy_reg, busy_next;
    logic [pss_pkg::CYC_W-1:0]   idle_reg, idle_next;
    logic [pss_pkg::CYC_W-1:0]   wake_reg, wake_next;
    logic [pss_pkg::SKIP_W-1:0]  skip_reg, skip_next;
    logic [LCNT_W-1:0]           left_reg, left_next;
    logic [LCNT_W-1:0]           total_reg, total_next;
    logic [LCNT_W-1:0]           resp_reg, resp_next;
    logic [NA_W-1:0]             addr_reg, addr_next;
    logic                        dir_reg, dir_next;
    logic [pss_pkg::TAG_W-1:0]   tag_reg, tag_next;

    // Helpers for one item
    logic                        s_fire;
    logic [pss_pkg::CYC_W-1:0]   idle_bump;
    logic [pss_pkg::CYC_W-1:0]   idle_low;
    logic [pss_pkg::SKIP_W-1:0]  skip_dec;
    logic                        busy_stay;
    logic [LRAW_W-1:0]           bytes_round;
    logic [LRAW_W-1:0]           lines_raw;
    logic [LCNT_W-1:0]           lines_sat;
    logic [PROD_W-1:0]           skip_prod;
    logic [pss_pkg::SKIP_W-1:0]  skip_sat;
    logic [pss_pkg::CYC_W-1:0]   exit_delay;
    pss_pkg::res_t               res;
    pss_pkg::res_t               out_data;
    logic                        buf_ready;

    // APB register access, no wait states.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[pss_pkg::PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            io_latency_reg   <= pss_pkg::IO_LAT_W'(1);
            enter_cycles_reg <= pss_pkg::CYC_W'(1000);
            low_exit_reg     <= pss_pkg::CYC_W'(100);
            idle_exit_reg    <= pss_pkg::CYC_W'(1000);
        end else if (cfg_write) begin
            case (reg_idx)
                pss_pkg::REG_IO_LATENCY: io_latency_reg   <= pwdata[pss_pkg::IO_LAT_W-1:0];
                pss_pkg::REG_ENTER:      enter_cycles_reg <= pwdata[pss_pkg::CYC_W-1:0];
                pss_pkg::REG_LOW_EXIT:   low_exit_reg     <= pwdata[pss_pkg::CYC_W-1:0];
                pss_pkg::REG_IDLE_EXIT:  idle_exit_reg    <= pwdata[pss_pkg::CYC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            pss_pkg::REG_IO_LATENCY: prdata = pss_pkg::PDATA_W'(io_latency_reg);
            pss_pkg::REG_ENTER:      prdata = pss_pkg::PDATA_W'(enter_cycles_reg);
            pss_pkg::REG_LOW_EXIT:   prdata = pss_pkg::PDATA_W'(low_exit_reg);
            pss_pkg::REG_IDLE_EXIT:  prdata = pss_pkg::PDATA_W'(idle_exit_reg);
            default:                 prdata = '0;
        endcase
    end

    assign s_ready = buf_ready;
    assign s_fire  = s_valid && s_ready;

    // Job sizing: lines rounded up and clamped, then the processing charge.
    assign bytes_round = {1'b0, s_job_bytes} + LRAW_W'(LINE_BYTES - 1);
    assign lines_raw   = LRAW_W'(bytes_round / LINE_BYTES);
    assign lines_sat   = (lines_raw > MAX_LINES_RAW) ? MAX_LINES_CNT : LCNT_W'(lines_raw);
    assign skip_prod   = PROD_W'(io_latency_reg) * PROD_W'(lines_sat);
    assign skip_sat    = (32'(skip_prod) > 32'(pss_pkg::SKIP_MAX)) ? pss_pkg::SKIP_MAX
                                                                   : pss_pkg::SKIP_W'(skip_prod);
    assign exit_delay  = (pm_reg == pss_pkg::PM_LOW) ? low_exit_reg : idle_exit_reg;

    // Saturating idle counts and the skip countdown.
    assign idle_bump = (idle_reg == pss_pkg::IDLE_MAX) ? idle_reg
                                                       : idle_reg + pss_pkg::CYC_W'(1);
    assign idle_low  = (pm_reg == pss_pkg::PM_LOW) ? idle_bump : idle_reg;
    assign skip_dec  = (skip_reg != '0) ? skip_reg - pss_pkg::SKIP_W'(1) : skip_reg;
    assign busy_stay = busy_reg && (resp_reg < total_reg);

    // Next state and result for the accepted item.
    always_comb begin
        pm_next    = pm_reg;
        busy_next  = busy_reg;
        idle_next  = idle_reg;
        wake_next  = wake_reg;
        skip_next  = skip_reg;
        left_next  = left_reg;
        total_next = total_reg;
        resp_next  = resp_reg;
        addr_next  = addr_reg;
        dir_next   = dir_reg;
        tag_next   = tag_reg;
        res        = '0;

        if (s_fire) begin
            case (s_func)
                pss_pkg::FUNC_TICK: begin
                    idle_next = idle_low;
                    if (wake_reg != '0) begin
                        // Wake-up delay running: count down, no work.
                        wake_next = wake_reg - pss_pkg::CYC_W'(1);
                        if (wake_reg == pss_pkg::CYC_W'(1)) begin
                            pm_next   = pss_pkg::PM_ACTIVE;
                            idle_next = '0;
                        end
                    end else if (idle_low >= enter_cycles_reg) begin
                        // Idle long enough: drop one power stage, if not already idle.
                        case (pm_reg)
                            pss_pkg::PM_ACTIVE: pm_next = pss_pkg::PM_LOW;
                            pss_pkg::PM_LOW:    pm_next = pss_pkg::PM_IDLE;
                            default:            pm_next = pm_reg;
                        endcase
                        idle_next = '0;
                    end else if (pm_reg == pss_pkg::PM_ACTIVE) begin
                        res.did_work = 1'b1;
                        skip_next    = skip_dec;
                        if (skip_dec == '0) begin
                            // Completion once every response is in.
                            if (busy_reg && !busy_stay) begin
                                busy_next     = 1'b0;
                                resp_next     = '0;
                                left_next     = '0;
                                res.job_done  = 1'b1;
                                res.done_tag  = tag_reg;
                            end
                            if (!busy_stay) begin
                                idle_next = idle_bump;
                            end else if (left_reg != '0 && s_mem_accept) begin
                                res.line_sent    = 1'b1;
                                res.line_addr    = pss_pkg::ADDR_W'(addr_reg);
                                res.line_is_read = dir_reg;
                                left_next        = left_reg - LCNT_W'(1);
                                addr_next        = addr_reg + NA_W'(LINE_BYTES);
                            end
                        end
                    end
                end
                pss_pkg::FUNC_REQ: begin
                    if (!busy_reg) begin
                        res.job_taken = 1'b1;
                        busy_next     = 1'b1;
                        left_next     = lines_sat;
                        total_next    = lines_sat;
                        resp_next     = '0;
                        addr_next     = s_job_addr[NA_W-1:0];
                        dir_next      = s_job_is_read;
                        tag_next      = s_job_tag;
                        idle_next     = '0;
                        skip_next     = skip_sat;
                        // A sleeping block starts its wake-up delay, or wakes at once if it is zero.
                        if (pm_reg != pss_pkg::PM_ACTIVE) begin
                            if (exit_delay == '0) begin
                                pm_next = pss_pkg::PM_ACTIVE;
                            end else begin
                                wake_next = exit_delay;
                            end
                        end
                    end
                end
                pss_pkg::FUNC_RESP: begin
                    if (resp_reg < MAX_LINES_CNT) begin
                        resp_next = resp_reg + LCNT_W'(1);
                    end
                end
                default: ;
            endcase
        end

        case (pm_next)
            pss_pkg::PM_ACTIVE: res.power_mode = pss_pkg::MODE_ACTIVE;
            pss_pkg::PM_LOW:    res.power_mode = pss_pkg::MODE_LOW;
            default:            res.power_mode = pss_pkg::MODE_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pm_reg    <= pss_pkg::PM_IDLE;
            busy_reg  <= 1'b0;
            idle_reg  <= '0;
            wake_reg  <= '0;
            skip_reg  <= '0;
            left_reg  <= '0;
            total_reg <= '0;
            resp_reg  <= '0;
            addr_reg  <= '0;
            dir_reg   <= 1'b0;
            tag_reg   <= '0;
        end else begin
            pm_reg    <= pm_next;
            busy_reg  <= busy_next;
            idle_reg  <= idle_next;
            wake_reg  <= wake_next;
            skip_reg  <= skip_next;
            left_reg  <= left_next;
            total_reg <= total_next;
            resp_reg  <= resp_next;
            addr_reg  <= addr_next;
            dir_reg   <= dir_next;
            tag_reg   <= tag_next;
        end
    end

    // Result buffer toward the m_ channel.
    pss_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (buf_ready),
        .push_data  (res),
        .pop_valid  (m_valid),
        .pop_ready  (m_ready),
        .pop_data   (out_data)
    );

    assign m_job_taken    = out_data.job_taken;
    assign m_line_sent    = out_data.line_sent;
    assign m_line_addr    = out_data.line_addr;
    assign m_line_is_read = out_data.line_is_read;
    assign m_job_done     = out_data.job_done;
    assign m_done_tag     = out_data.done_tag;
    assign m_power_mode   = out_data.power_mode;
    assign m_did_work     = out_data.did_work;

endmodule

// ===== verif/ip_power_state_request_sequencer_unit_tb.sv =====
module ip_power_state_request_sequencer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pss_pkg::*;

    // Item kind that the block must ignore.
    localparam logic [FUNC_W-1:0] FUNC_BAD = 2'd3;

    localparam int LINE_CNT_W     = $clog2(MAX_LINES_DEF + 1);
    localparam int GAP_MAX        = 6;
    localparam int STALL_LIMIT    = 4000;
    localparam int PHASE_ITEMS    = 260;
    localparam int OVERSIZE_TICKS = 24;
    localparam int OVERSIZE_RESPS = 16;
    localparam int DRAIN_MAX      = 200;
    localparam logic [ADDR_W-1:0] LINE_STEP = ADDR_W'(LINE_BYTES_DEF);

    // One input item, one field per port.
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic               mem_accept;
        logic [ADDR_W-1:0]  addr;
        logic [BYTES_W-1:0] bytes;
        logic               rd;
        logic [TAG_W-1:0]   tag;
    } seq_item_t;

    // Shadow copy of the four configuration registers.
    typedef struct packed {
        logic [IO_LAT_W-1:0] io_lat;
        logic [CYC_W-1:0]    enter_cyc;
        logic [CYC_W-1:0]    low_exit;
        logic [CYC_W-1:0]    idle_exit;
    } seq_cfg_t;

    // Architectural state of the sequencer as the predictor sees it.
    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic                  busy;
        logic [CYC_W-1:0]      idle_cnt;
        logic [CYC_W-1:0]      wake_cnt;
        logic [SKIP_W-1:0]     skip_cnt;
        logic [LINE_CNT_W-1:0] lines_left;
        logic [LINE_CNT_W-1:0] lines_total;
        logic [LINE_CNT_W-1:0] resp_cnt;
        logic [ADDR_W-1:0]     next_addr;
        logic                  dir_rd;
        logic [TAG_W-1:0]      tag;
    } seq_state_t;

    // One row of the directed stimulus: a register write or an item.
    typedef struct packed {
        logic                 is_cfg;
        logic [REG_IDX_W-1:0] reg_idx;
        logic [PDATA_W-1:0]   value;
        seq_item_t            item;
        logic                 typed;
        res_t                 want;
    } dir_row_t;

    // Register settings of the random phases: latency, enter, low exit, idle exit.
    localparam seq_cfg_t PHASES [5] = '{
        '{8'd1,   16'd6,     16'd2,     16'd4},
        '{8'd0,   16'd1,     16'd0,     16'd0},
        '{8'd255, 16'd65535, 16'd65535, 16'd0},
        '{8'd2,   16'd0,     16'd1,     16'd3},
        '{8'd3,   16'd12,    16'd5,     16'd0}
    };
    localparam seq_cfg_t FLOOD_CFG = '{8'd0, 16'd40, 16'd1, 16'd1};

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [PADDR_W-1:0]   paddr         = '0;
    logic [PDATA_W-1:0]   pwdata        = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [FUNC_W-1:0]    s_func        = '0;
    logic                 s_mem_accept  = 1'b0;
    logic [ADDR_W-1:0]    s_job_addr    = '0;
    logic [BYTES_W-1:0]   s_job_bytes   = '0;
    logic                 s_job_is_read = 1'b0;
    logic [TAG_W-1:0]     s_job_tag     = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic                 m_job_taken;
    logic                 m_line_sent;
    logic [ADDR_W-1:0]    m_line_addr;
    logic                 m_line_is_read;
    logic                 m_job_done;
    logic [TAG_W-1:0]     m_done_tag;
    logic [MODE_W-1:0]    m_power_mode;
    logic                 m_did_work;

    seq_state_t seq_st;
    seq_cfg_t   cfg_sh;
    res_t       pending_results[$];
    dir_row_t   dir_table[$];
    bit         calm = 1'b0;
    int         err_count = 0;
    int         results_seen = 0;
    int         jobs_done = 0;
    int         lines_seen = 0;
    int         settings_done = 0;
    int         kind_count[4] = '{0, 0, 0, 0};
    int         rx_wait = 0;
    int         quiet_cycles = 0;

    ip_power_state_request_sequencer_unit uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_mem_accept   (s_mem_accept),
        .s_job_addr     (s_job_addr),
        .s_job_bytes    (s_job_bytes),
        .s_job_is_read  (s_job_is_read),
        .s_job_tag      (s_job_tag),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_job_taken    (m_job_taken),
        .m_line_sent    (m_line_sent),
        .m_line_addr    (m_line_addr),
        .m_line_is_read (m_line_is_read),
        .m_job_done     (m_job_done),
        .m_done_tag     (m_done_tag),
        .m_power_mode   (m_power_mode),
        .m_did_work     (m_did_work)
    );

    // 8 ns clock.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      results_seen, name, got, want));
        end
    endtask

    function automatic seq_item_t mk_item(input logic [FUNC_W-1:0] f, input logic acc,
                                          input logic [ADDR_W-1:0] a,
                                          input logic [BYTES_W-1:0] b, input logic rd,
                                          input logic [TAG_W-1:0] t);
        seq_item_t it;
        it.func       = f;
        it.mem_accept = acc;
        it.addr       = a;
        it.bytes      = b;
        it.rd         = rd;
        it.tag        = t;
        return it;
    endfunction

    function automatic dir_row_t item_row(input seq_item_t it);
        dir_row_t row;
        row      = '0;
        row.item = it;
        return row;
    endfunction

    function automatic dir_row_t want_row(input seq_item_t it, input res_t want);
        dir_row_t row;
        row       = item_row(it);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic dir_row_t cfg_row(input logic [REG_IDX_W-1:0] idx,
                                         input logic [PDATA_W-1:0] val);
        dir_row_t row;
        row         = '0;
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.value   = val;
        return row;
    endfunction

    // Advances the sequencer state by one item and returns the result it causes.
    function automatic res_t next_sequencer_result(input seq_item_t it);
        res_t              r;
        bit                go;
        int unsigned       lines;
        int unsigned       skip_calc;
        logic [CYC_W-1:0]  exit_delay;
        r = '0;
        case (it.func)
            FUNC_TICK: begin
                // Power checks: low power counts idle ticks, a wake delay runs
                // down, then the idle threshold steps the mode down.
                if (seq_st.mode == MODE_LOW && seq_st.idle_cnt != IDLE_MAX)
                    seq_st.idle_cnt++;
                if (seq_st.wake_cnt != 0) begin
                    seq_st.wake_cnt--;
                    if (seq_st.wake_cnt == 0) begin
                        seq_st.mode     = MODE_ACTIVE;
                        seq_st.idle_cnt = '0;
                    end
                    go = 1'b0;
                end else if (seq_st.idle_cnt >= cfg_sh.enter_cyc) begin
                    if (seq_st.mode == MODE_ACTIVE)
                        seq_st.mode = MODE_LOW;
                    else if (seq_st.mode == MODE_LOW)
                        seq_st.mode = MODE_IDLE;
                    seq_st.idle_cnt = '0;
                    go = 1'b0;
                end else begin
                    go = (seq_st.mode == MODE_ACTIVE);
                end
                // Work: burn processing ticks, complete, then issue one line.
                if (go) begin
                    r.did_work = 1'b1;
                    if (seq_st.skip_cnt != 0)
                        seq_st.skip_cnt--;
                    if (seq_st.skip_cnt == 0) begin
                        if (seq_st.busy && seq_st.resp_cnt >= seq_st.lines_total) begin
                            seq_st.busy       = 1'b0;
                            seq_st.resp_cnt   = '0;
                            seq_st.lines_left = '0;
                            r.job_done        = 1'b1;
                            r.done_tag        = seq_st.tag;
                        end
                        if (!seq_st.busy) begin
                            if (seq_st.idle_cnt != IDLE_MAX)
                                seq_st.idle_cnt++;
                        end else if (seq_st.lines_left != 0 && it.mem_accept) begin
                            r.line_sent    = 1'b1;
                            r.line_addr    = seq_st.next_addr;
                            r.line_is_read = seq_st.dir_rd;
                            seq_st.lines_left--;
                            seq_st.next_addr += LINE_STEP;
                        end
                    end
                end
            end
            FUNC_REQ: begin
                if (!seq_st.busy) begin
                    r.job_taken = 1'b1;
                    lines = (int'(it.bytes) + LINE_BYTES_DEF - 1) / LINE_BYTES_DEF;
                    if (lines > MAX_LINES_DEF)
                        lines = MAX_LINES_DEF;
                    seq_st.busy        = 1'b1;
                    seq_st.lines_left  = LINE_CNT_W'(lines);
                    seq_st.lines_total = LINE_CNT_W'(lines);
                    seq_st.resp_cnt    = '0;
                    seq_st.next_addr   = it.addr;
                    seq_st.dir_rd      = it.rd;
                    seq_st.tag         = it.tag;
                    seq_st.idle_cnt    = '0;
                    skip_calc = int'(cfg_sh.io_lat) * lines;
                    seq_st.skip_cnt = (skip_calc > int'(SKIP_MAX)) ? SKIP_MAX
                                                                   : SKIP_W'(skip_calc);
                    // A request in a sleeping mode starts the wake delay, or wakes at once if it is zero.
                    if (seq_st.mode != MODE_ACTIVE) begin
                        exit_delay = (seq_st.mode == MODE_LOW) ? cfg_sh.low_exit
                                                               : cfg_sh.idle_exit;
                        if (exit_delay == 0)
                            seq_st.mode = MODE_ACTIVE;
                        else
                            seq_st.wake_cnt = exit_delay;
                    end
                end
            end
            FUNC_RESP: begin
                if (seq_st.resp_cnt < MAX_LINES_DEF)
                    seq_st.resp_cnt++;
            end
            default: ;
        endcase
        r.power_mode = seq_st.mode;
        return r;
    endfunction

    // Random item shaped after the current job: requests when free, responses
    // for lines already sent, ticks otherwise, plus some noise.
    function automatic seq_item_t make_random_item(input bit allow_req);
        seq_item_t      it;
        logic [63:0]    wide;
        logic [31:0]    bits;
        int             pick;
        int             size_pick;
        int unsigned    owed;
        wide = {$urandom(), $urandom()};
        bits = $urandom();
        it.addr       = wide[ADDR_W-1:0];
        it.tag        = bits[TAG_W-1:0];
        it.rd         = bits[16];
        it.mem_accept = (bits[19:17] != 3'd0);
        it.bytes      = BYTES_W'($urandom_range(0, 2048));
        owed = allow_req ? int'(seq_st.lines_total - seq_st.lines_left)
                         : int'(seq_st.lines_total);
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            it.func  = FUNC_BAD;
            it.bytes = BYTES_W'($urandom());
        end else if (allow_req && ((!seq_st.busy && pick < 55) || pick < 7)) begin
            it.func = FUNC_REQ;
            if (bits[23:21] == 3'd0)
                it.addr[ADDR_W-1:12] = '1;
            size_pick = $urandom_range(0, 19);
            if (size_pick == 0)
                it.bytes = '0;
            else if (cfg_sh.io_lat > 8)
                it.bytes = BYTES_W'($urandom_range(1, 128));
            else if (size_pick < 16)
                it.bytes = BYTES_W'($urandom_range(1, 512));
            else
                it.bytes = BYTES_W'($urandom_range(513, 6000));
        end else if (seq_st.busy && int'(seq_st.resp_cnt) < owed && pick < 50) begin
            it.func = FUNC_RESP;
        end else if (pick < 53) begin
            it.func = FUNC_RESP;
        end else begin
            it.func = FUNC_TICK;
        end
        return it;
    endfunction

    // Sends one item after a random gap (none while calm) and records its expected result.
    task automatic push_item(input seq_item_t it, input bit typed, input res_t want);
        int   gap;
        res_t pred;
        gap = calm ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= it.func;
        s_mem_accept  <= it.mem_accept;
        s_job_addr    <= it.addr;
        s_job_bytes   <= it.bytes;
        s_job_is_read <= it.rd;
        s_job_tag     <= it.tag;
        do @(posedge aclk); while (!s_ready);
        pred = next_sequencer_result(it);
        pending_results.push_back(typed ? want : pred);
        kind_count[it.func]++;
    endtask

    task automatic apb_transfer(input bit wr, input logic [REG_IDX_W-1:0] idx,
                                input logic [PDATA_W-1:0] wdata,
                                output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
    endtask

    // Waits for the block to go quiet, writes one register and reads it back.
    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [PDATA_W-1:0] val);
        logic [PDATA_W-1:0] kept;
        logic [PDATA_W-1:0] rb;
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
        case (idx)
            REG_IO_LATENCY: begin
                cfg_sh.io_lat = val[IO_LAT_W-1:0];
                kept = PDATA_W'(cfg_sh.io_lat);
            end
            REG_ENTER: begin
                cfg_sh.enter_cyc = val[CYC_W-1:0];
                kept = PDATA_W'(cfg_sh.enter_cyc);
            end
            REG_LOW_EXIT: begin
                cfg_sh.low_exit = val[CYC_W-1:0];
                kept = PDATA_W'(cfg_sh.low_exit);
            end
            default: begin
                cfg_sh.idle_exit = val[CYC_W-1:0];
                kept = PDATA_W'(cfg_sh.idle_exit);
            end
        endcase
        apb_transfer(1'b1, idx, val, rb);
        apb_transfer(1'b0, idx, '0, rb);
        if (rb !== kept)
            report_mismatch($sformatf("register %0d read back 0x%0h, expected 0x%0h",
                                      idx, rb, kept));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_setting(input seq_cfg_t c);
        write_register(REG_IO_LATENCY, PDATA_W'(c.io_lat));
        write_register(REG_ENTER, PDATA_W'(c.enter_cyc));
        write_register(REG_LOW_EXIT, PDATA_W'(c.low_exit));
        write_register(REG_IDLE_EXIT, PDATA_W'(c.idle_exit));
        settings_done++;
    endtask

    // Result side: random back-pressure and a field-by-field check of each transfer.
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                got.job_taken    = m_job_taken;
                got.line_sent    = m_line_sent;
                got.line_addr    = m_line_addr;
                got.line_is_read = m_line_is_read;
                got.job_done     = m_job_done;
                got.done_tag     = m_done_tag;
                got.power_mode   = m_power_mode;
                got.did_work     = m_did_work;
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result transfer after %0d",
                                              results_seen));
                end else begin
                    want = pending_results.pop_front();
                    check_field("job_taken", 64'(got.job_taken), 64'(want.job_taken));
                    check_field("line_sent", 64'(got.line_sent), 64'(want.line_sent));
                    check_field("line_addr", 64'(got.line_addr), 64'(want.line_addr));
                    check_field("line_is_read", 64'(got.line_is_read),
                                64'(want.line_is_read));
                    check_field("job_done", 64'(got.job_done), 64'(want.job_done));
                    check_field("done_tag", 64'(got.done_tag), 64'(want.done_tag));
                    check_field("power_mode", 64'(got.power_mode), 64'(want.power_mode));
                    check_field("did_work", 64'(got.did_work), 64'(want.did_work));
                end
                results_seen++;
                if (got.job_done === 1'b1)
                    jobs_done++;
                if (got.line_sent === 1'b1)
                    lines_seen++;
                rx_wait = calm ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus: directed table, random phases, then one oversize job.
    initial begin
        res_t w;
        int   n;
        seq_st      = '0;
        seq_st.mode = MODE_IDLE;
        cfg_sh      = '{8'd1, 16'd1000, 16'd100, 16'd1000};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Out of reset the block sleeps in idle and does nothing.
        w = '0;
        w.power_mode = MODE_IDLE;
        dir_table.push_back(want_row(mk_item(FUNC_TICK, 1'b1, '0, '0, 1'b0, '0), w));
        dir_table.push_back(want_row(mk_item(FUNC_BAD, 1'b1, '1, '1, 1'b1, '1), w));
        dir_table.push_back(want_row(mk_item(FUNC_RESP, 1'b0, '0, '0, 1'b0, '0), w));
        dir_table.push_back(cfg_row(REG_IO_LATENCY, 32'd0));
        dir_table.push_back(cfg_row(REG_ENTER, 32'd3));
        dir_table.push_back(cfg_row(REG_LOW_EXIT, 32'd0));
        dir_table.push_back(cfg_row(REG_IDLE_EXIT, 32'd0));
        // With a zero exit delay a request wakes the block at once.
        w = '0;
        w.job_taken  = 1'b1;
        w.power_mode = MODE_ACTIVE;
        dir_table.push_back(want_row(mk_item(FUNC_REQ, 1'b0, '1, '0, 1'b1, '1), w));
        // A zero-byte job completes on its first working tick.
        w = '0;
        w.did_work   = 1'b1;
        w.job_done   = 1'b1;
        w.done_tag   = '1;
        w.power_mode = MODE_ACTIVE;
        dir_table.push_back(want_row(mk_item(FUNC_TICK, 1'b0, '0, '0, 1'b0, '0), w));
        // Three lines that wrap past the top of the address space.
        dir_table.push_back(item_row(mk_item(FUNC_REQ, 1'b0, 48'hFFFF_FFFF_FF80, 19'd129,
                                             1'b0, 16'h1234)));
        w = '0;
        w.power_mode = MODE_ACTIVE;
        dir_table.push_back(want_row(mk_item(FUNC_REQ, 1'b1, '0, 19'd64, 1'b1, 16'h5555),
                                     w));
        dir_table.push_back(item_row(mk_item(FUNC_TICK, 1'b1, '0, '0, 1'b0, '0)));
        dir_table.push_back(item_row(mk_item(FUNC_TICK, 1'b0, '0, '0, 1'b0, '0)));
        dir_table.push_back(item_row(mk_item(FUNC_TICK, 1'b1, '0, '0, 1'b0, '0)));
        dir_table.push_back(item_row(mk_item(FUNC_TICK, 1'b1, '0, '0, 1'b0, '0)));
        // One response more than lines sent.
        repeat (4)
            dir_table.push_back(item_row(mk_item(FUNC_RESP, 1'b0, '0, '0, 1'b0, '0)));
        // Completion, idle count-up and a step down to low power.
        repeat (5)
            dir_table.push_back(item_row(mk_item(FUNC_TICK, 1'b1, '0, '0, 1'b0, '0)));
        dir_table.push_back(item_row(mk_item(FUNC_REQ, 1'b0, 48'h0000_1234_5678, 19'd64,
                                             1'b1, 16'hABCD)));

        foreach (dir_table[i]) begin
            if (dir_table[i].is_cfg)
                write_register(dir_table[i].reg_idx, dir_table[i].value);
            else
                push_item(dir_table[i].item, dir_table[i].typed, dir_table[i].want);
        end
        settings_done++;

        // Random phases, one register setting each.
        foreach (PHASES[p]) begin
            apply_setting(PHASES[p]);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                push_item(make_random_item(1'b1), 1'b0, '0);
            end
        end

        // Finish any open job, then start one oversize job whose line count
        // clamps, and let it issue lines and collect some responses.
        calm = 1'b0;
        apply_setting(FLOOD_CFG);
        n = 0;
        while (seq_st.busy && n < DRAIN_MAX) begin
            push_item(make_random_item(1'b0), 1'b0, '0);
            n++;
        end
        push_item(mk_item(FUNC_REQ, 1'b1, {16'h8000, $urandom()}, '1, 1'b1, 16'h0F0F),
                  1'b0, '0);
        calm = 1'b1;
        repeat (OVERSIZE_TICKS)
            push_item(mk_item(FUNC_TICK, 1'b1, '0, '0, 1'b0, '0), 1'b0, '0);
        repeat (OVERSIZE_RESPS)
            push_item(mk_item(FUNC_RESP, 1'b0, '0, '0, 1'b0, '0), 1'b0, '0);
        calm = 1'b0;
        repeat (6) push_item(mk_item(FUNC_TICK, 1'b1, '0, '0, 1'b0, '0), 1'b0, '0);

        // Drain the result side and let the pipeline settle.
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Run covered %0d ticks, %0d requests, %0d responses, %0d unknown items",
                 kind_count[FUNC_TICK], kind_count[FUNC_REQ], kind_count[FUNC_RESP],
                 kind_count[FUNC_BAD]);
        $display("over %0d register settings: %0d results, %0d jobs done, %0d lines sent.",
                 settings_done, results_seen, jobs_done, lines_seen);
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pss_pkg.sv
rtl/pss_out_buf.sv
rtl/ip_power_state_request_sequencer_unit.sv
verif/ip_power_state_request_sequencer_unit_tb.sv
